// File: sv/twm_pkg.sv
// Shared types and constants for the two-wire bus master byte engine.
// No dependencies; used by twm_engine, two_wire_master_byte_engine and tb_top.
`default_nettype none

package twm_pkg;

    // Command codes carried on the input channel.
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_RD_ACK   = 3'd4;
    localparam logic [2:0] CMD_RD_NACK  = 3'd5;
    localparam logic [2:0] CMD_CHK_ACK  = 3'd6;
    localparam logic [2:0] CMD_RESERVED = 3'd7;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd9;

    // A segment is the run of line changes between two waits.
    localparam int unsigned SEG_W = 5;
    localparam logic [SEG_W-1:0] SEG_FIRST     = 5'd0;
    localparam logic [SEG_W-1:0] SEG_SECOND    = 5'd1;
    localparam logic [SEG_W-1:0] SEG_THIRD     = 5'd2;
    localparam logic [SEG_W-1:0] SEG_FOURTH    = 5'd3;
    localparam logic [SEG_W-1:0] SEG_LAST_BIT  = 5'd16;
    localparam logic [SEG_W-1:0] SEG_TAIL_A    = 5'd17;
    localparam logic [SEG_W-1:0] SEG_TAIL_B    = 5'd18;
    localparam logic [SEG_W-1:0] SEG_TAIL_C    = 5'd19;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_byte;
        logic       ack_seen;
    } t_result;

    typedef struct packed {
        logic idle;
        logic counting;
    } t_eng_stat;

endpackage

`default_nettype wire

// File: sv/two_wire_master_byte_engine.sv
// Top level of the two-wire bus master: input register, phase register,
// sequencing engine and result register. Depends on twm_pkg and twm_engine.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_cmd, i_wr_byte, i_sda_in
//  out     | from block| o_out_valid / i_out_stall  | o_scl_level .. o_ack_seen
//  cfg     | to block  | i_cfg_wr_en                | i_cfg_wr_data (phase_ticks)
//
// Every accepted item is one bus tick and produces exactly one result item.
// An item waits in the input register and is evaluated into the result register once
// it is empty or read, so one item per cycle flows while the output is not stalled.
// The engine state advances only when an item moves into the result register.
// A stalled result holds; the input side stalls only while both registers are full.
// Reset is synchronous and active low; it clears both valid flags and the bus state.
`default_nettype none

module two_wire_master_byte_engine (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_cmd,
    input  wire logic [7:0] i_wr_byte,
    input  wire logic       i_sda_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_scl_level,
    output logic            o_sda_level,
    output logic            o_sda_drive,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic [7:0]      o_rd_byte,
    output logic            o_ack_seen
);

    logic [7:0]          r_phase_ticks;
    logic                r_in_valid;
    logic [2:0]          r_cmd;
    logic [7:0]          r_wr_byte;
    logic                r_sda_in;
    logic                r_out_valid;
    twm_pkg::t_result    r_result;
    twm_pkg::t_result    eng_result;
    twm_pkg::t_eng_stat  eng_stat;
    logic                step;
    logic                in_take;

    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= twm_pkg::PHASE_TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_phase_ticks <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd     <= i_cmd;
            r_wr_byte <= i_wr_byte;
            r_sda_in  <= i_sda_in;
        end
    end

    twm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_phase_ticks (r_phase_ticks),
        .i_cmd         (r_cmd),
        .i_wr_byte     (r_wr_byte),
        .i_sda_in      (r_sda_in),
        .o_result      (eng_result),
        .o_stat        (eng_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= eng_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_result.scl_level;
    assign o_sda_level = r_result.sda_level;
    assign o_sda_drive = r_result.sda_drive;
    assign o_busy_res  = r_result.busy_res;
    assign o_done_res  = r_result.done_res;
    assign o_rd_byte   = r_result.rd_byte;
    assign o_ack_seen  = r_result.ack_seen;

`ifndef ASSERT_OFF
    // A completing command leaves the engine idle on the same tick.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // A wait is only ever counted while a command is active.
    a_wait_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.counting |-> !eng_stat.idle)
        else $error("wait counter running while idle");

    // Every evaluated tick lands in the result register.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("evaluated item lost");

    // The input side only stalls when both registers are occupied and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

// File: sv/twm_engine.sv
// Bus sequencing engine: holds the command state and line registers and
// computes the result of one tick. Depends on twm_pkg.
`default_nettype none

module twm_engine (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_phase_ticks,
    input  wire logic [2:0]       i_cmd,
    input  wire logic [7:0]       i_wr_byte,
    input  wire logic             i_sda_in,
    output twm_pkg::t_result      o_result,
    output twm_pkg::t_eng_stat    o_stat
);

    logic [2:0]                 r_op,    n_op;
    logic [7:0]                 r_wait,  n_wait;
    logic [twm_pkg::SEG_W-1:0]  r_seg,   n_seg;
    logic [7:0]                 r_shift, n_shift;
    logic [7:0]                 r_rd,    n_rd;
    logic                       r_ack,   n_ack;
    logic                       r_scl,   n_scl;
    logic                       r_sda,   n_sda;
    logic                       r_drv,   n_drv;

    logic                       idle;
    logic                       launch;
    logic [2:0]                 op_eff;
    logic [twm_pkg::SEG_W-1:0]  seg_eff;
    logic [7:0]                 shift_eff;
    logic                       fin;
    logic                       done;

    assign idle   = (r_op == twm_pkg::CMD_NONE);
    assign launch = idle && (i_cmd != twm_pkg::CMD_NONE) && (i_cmd != twm_pkg::CMD_RESERVED);

    always_comb begin
        op_eff    = launch ? i_cmd : r_op;
        seg_eff   = launch ? twm_pkg::SEG_FIRST : r_seg;
        shift_eff = (launch && i_cmd == twm_pkg::CMD_WRITE) ? i_wr_byte : r_shift;

        n_op    = r_op;
        n_wait  = r_wait;
        n_seg   = r_seg;
        n_shift = r_shift;
        n_rd    = r_rd;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        fin     = 1'b0;
        done    = 1'b0;

        if (!idle && r_wait != 8'd0) begin
            n_wait = r_wait - 8'd1;
        end else if (launch || !idle) begin
            n_shift = shift_eff;
            unique case (op_eff)
                twm_pkg::CMD_START: begin
                    priority if (seg_eff == twm_pkg::SEG_FIRST) begin
                        n_drv = 1'b1;
                        n_scl = 1'b1;
                    end else if (seg_eff == twm_pkg::SEG_SECOND) begin
                        n_sda = 1'b1;
                    end else if (seg_eff == twm_pkg::SEG_THIRD) begin
                        n_sda = 1'b0;
                    end else if (seg_eff == twm_pkg::SEG_FOURTH) begin
                        n_scl = 1'b0;
                        fin   = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                twm_pkg::CMD_STOP: begin
                    priority if (seg_eff == twm_pkg::SEG_FIRST) begin
                        n_drv = 1'b1;
                        n_sda = 1'b0;
                    end else if (seg_eff == twm_pkg::SEG_SECOND) begin
                        n_scl = 1'b0;
                    end else if (seg_eff == twm_pkg::SEG_THIRD) begin
                        n_scl = 1'b1;
                    end else if (seg_eff == twm_pkg::SEG_FOURTH) begin
                        n_sda = 1'b1;
                        fin   = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                twm_pkg::CMD_WRITE: begin
                    priority if (seg_eff == twm_pkg::SEG_FIRST) begin
                        n_sda = shift_eff[7];
                    end else if (seg_eff == twm_pkg::SEG_LAST_BIT) begin
                        // After the last bit, shift, release data and hold the clock high for the ack.
                        n_shift = {shift_eff[6:0], 1'b0};
                        n_drv   = 1'b0;
                        n_scl   = 1'b1;
                    end else if (seg_eff == twm_pkg::SEG_TAIL_A) begin
                        n_scl = 1'b0;
                    end else if (seg_eff == twm_pkg::SEG_TAIL_B) begin
                        n_drv = 1'b1;
                        fin   = 1'b1;
                    end else if (seg_eff > twm_pkg::SEG_TAIL_B) begin
                        fin = 1'b1;
                    end else if (seg_eff[0]) begin
                        n_scl = 1'b1;
                    end else begin
                        // Falling edge, shift, and present the next bit.
                        n_scl   = 1'b0;
                        n_shift = {shift_eff[6:0], 1'b0};
                        n_sda   = shift_eff[6];
                    end
                end
                twm_pkg::CMD_RD_ACK, twm_pkg::CMD_RD_NACK: begin
                    priority if (seg_eff == twm_pkg::SEG_FIRST) begin
                        n_drv = 1'b0;
                    end else if (seg_eff == twm_pkg::SEG_TAIL_A) begin
                        n_drv = 1'b1;
                        n_rd  = shift_eff;
                        n_sda = (op_eff != twm_pkg::CMD_RD_ACK);
                    end else if (seg_eff == twm_pkg::SEG_TAIL_B) begin
                        n_scl = 1'b1;
                    end else if (seg_eff == twm_pkg::SEG_TAIL_C) begin
                        n_scl = 1'b0;
                        fin   = 1'b1;
                    end else if (seg_eff > twm_pkg::SEG_TAIL_C) begin
                        fin = 1'b1;
                    end else if (seg_eff[0]) begin
                        n_scl = 1'b1;
                    end else begin
                        n_shift = {shift_eff[6:0], i_sda_in};
                        n_scl   = 1'b0;
                    end
                end
                twm_pkg::CMD_CHK_ACK: begin
                    priority if (seg_eff == twm_pkg::SEG_FIRST) begin
                        n_drv = 1'b0;
                        n_scl = 1'b1;
                    end else if (seg_eff == twm_pkg::SEG_SECOND) begin
                        n_ack = ~i_sda_in;
                        n_scl = 1'b0;
                        n_drv = 1'b1;
                        fin   = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase

            if (fin) begin
                n_op   = twm_pkg::CMD_NONE;
                n_seg  = twm_pkg::SEG_FIRST;
                n_wait = 8'd0;
                done   = 1'b1;
            end else begin
                n_op   = op_eff;
                n_seg  = seg_eff + 5'd1;
                n_wait = (i_phase_ticks != 8'd0) ? i_phase_ticks - 8'd1 : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= twm_pkg::CMD_NONE;
            r_wait  <= 8'd0;
            r_seg   <= twm_pkg::SEG_FIRST;
            r_shift <= 8'd0;
            r_rd    <= 8'd0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else if (i_step) begin
            r_op    <= n_op;
            r_wait  <= n_wait;
            r_seg   <= n_seg;
            r_shift <= n_shift;
            r_rd    <= n_rd;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
        end
    end

    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.sda_drive = n_drv;
        o_result.busy_res  = (n_op != twm_pkg::CMD_NONE);
        o_result.done_res  = done;
        o_result.rd_byte   = n_rd;
        o_result.ack_seen  = n_ack;
        o_stat.idle        = idle;
        o_stat.counting    = (r_wait != 8'd0);
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for two_wire_master_byte_engine: random bursts of bus ticks in,
// every result tick checked against a cycle-exact model of the bit-level sequencer.
// Depends on twm_pkg and the RTL of the block only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Line actions of the sequencer, one per step.
    typedef enum logic [3:0] {
        MO_END, MO_WAIT, MO_SCL_LO, MO_SCL_HI, MO_SDA_LO, MO_SDA_HI, MO_SDA_BIT,
        MO_SHIFT, MO_RELEASE, MO_DRIVE, MO_SAMPLE, MO_STORE, MO_ACK_BIT, MO_ACK_CHECK
    } t_micro;

    typedef struct {
        logic [2:0] op;
        logic [7:0] wait_left;
        logic [5:0] step;
        logic [7:0] shreg;
        logic [7:0] rd;
        logic       ack;
        logic       scl;
        logic       sda;
        logic       drv;
        logic [7:0] phase;
    } t_bus_state;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wr_byte;
        logic       sda_in;
    } t_tick_item;

    localparam int SDA_RANDOM = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_LOW    = 2;
    localparam int HOLD_CYCLES = 80;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_cmd = twm_pkg::CMD_NONE;
    logic [7:0] i_wr_byte = 8'd0;
    logic       i_sda_in = 1'b1;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_sda_drive;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rd_byte;
    logic       o_ack_seen;

    two_wire_master_byte_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_wr_byte    (i_wr_byte),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rd_byte    (o_rd_byte),
        .o_ack_seen   (o_ack_seen)
    );

    t_bus_state        chk_bus;
    t_bus_state        gen_bus;
    t_tick_item        pending_q[$];
    twm_pkg::t_result  tick_expect_q[$];
    int                queued_total = 0;
    int                checked_total = 0;
    int                errors = 0;
    int                hold_req = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                stall_mode = 0;
    int                mode_left = 0;
    int                stall_cyc = 0;
    int                gap_left = 0;
    int                burst_left = 0;
    t_tick_item        next_item;
    twm_pkg::t_result  predicted;
    twm_pkg::t_result  want;

    function automatic t_bus_state bus_reset_state();
        t_bus_state s;
        s.op = twm_pkg::CMD_NONE;
        s.wait_left = 8'd0;
        s.step = 6'd0;
        s.shreg = 8'd0;
        s.rd = 8'd0;
        s.ack = 1'b0;
        s.scl = 1'b1;
        s.sda = 1'b1;
        s.drv = 1'b1;
        s.phase = twm_pkg::PHASE_TICKS_RESET;
        return s;
    endfunction

    // Step table of each command; bit-level parts repeat every 6 (write) or 5 (read) steps.
    function automatic t_micro micro_at(input logic [2:0] op, input logic [5:0] idx);
        int i;
        i = idx;
        case (op)
            twm_pkg::CMD_START: begin
                case (i)
                    0: return MO_DRIVE;
                    1: return MO_SCL_HI;
                    2, 4, 6: return MO_WAIT;
                    3: return MO_SDA_HI;
                    5: return MO_SDA_LO;
                    7: return MO_SCL_LO;
                    default: return MO_END;
                endcase
            end
            twm_pkg::CMD_STOP: begin
                case (i)
                    0: return MO_DRIVE;
                    1: return MO_SDA_LO;
                    2, 4, 6: return MO_WAIT;
                    3: return MO_SCL_LO;
                    5: return MO_SCL_HI;
                    7: return MO_SDA_HI;
                    default: return MO_END;
                endcase
            end
            twm_pkg::CMD_WRITE: begin
                if (i < 48) begin
                    case (i % 6)
                        0: return MO_SDA_BIT;
                        1, 3: return MO_WAIT;
                        2: return MO_SCL_HI;
                        4: return MO_SCL_LO;
                        default: return MO_SHIFT;
                    endcase
                end
                case (i - 48)
                    0: return MO_RELEASE;
                    1: return MO_SCL_HI;
                    2, 4: return MO_WAIT;
                    3: return MO_SCL_LO;
                    5: return MO_DRIVE;
                    default: return MO_END;
                endcase
            end
            twm_pkg::CMD_RD_ACK, twm_pkg::CMD_RD_NACK: begin
                if (i == 0) return MO_RELEASE;
                if (i == 1) return MO_WAIT;
                if (i < 42) begin
                    case ((i - 2) % 5)
                        0: return MO_SCL_HI;
                        1, 4: return MO_WAIT;
                        2: return MO_SAMPLE;
                        default: return MO_SCL_LO;
                    endcase
                end
                case (i - 42)
                    0: return MO_DRIVE;
                    1: return MO_STORE;
                    2: return MO_ACK_BIT;
                    3, 5: return MO_WAIT;
                    4: return MO_SCL_HI;
                    6: return MO_SCL_LO;
                    default: return MO_END;
                endcase
            end
            twm_pkg::CMD_CHK_ACK: begin
                case (i)
                    0: return MO_RELEASE;
                    1: return MO_SCL_HI;
                    2: return MO_WAIT;
                    3: return MO_ACK_CHECK;
                    4: return MO_SCL_LO;
                    5: return MO_DRIVE;
                    default: return MO_END;
                endcase
            end
            default: return MO_END;
        endcase
    endfunction

    // Runs steps until the next wait or the end of the command; returns 1 on completion.
    function automatic logic run_steps(inout t_bus_state s, input logic sda_in);
        t_micro m;
        for (int g = 0; g < 64; g++) begin
            m = micro_at(s.op, s.step);
            s.step = s.step + 6'd1;
            case (m)
                MO_WAIT: begin
                    s.wait_left = (s.phase != 8'd0) ? s.phase - 8'd1 : 8'd0;
                    return 1'b0;
                end
                MO_SCL_LO:    s.scl = 1'b0;
                MO_SCL_HI:    s.scl = 1'b1;
                MO_SDA_LO:    s.sda = 1'b0;
                MO_SDA_HI:    s.sda = 1'b1;
                MO_SDA_BIT:   s.sda = s.shreg[7];
                MO_SHIFT:     s.shreg = {s.shreg[6:0], 1'b0};
                MO_RELEASE:   s.drv = 1'b0;
                MO_DRIVE:     s.drv = 1'b1;
                MO_SAMPLE:    s.shreg = {s.shreg[6:0], sda_in};
                MO_STORE:     s.rd = s.shreg;
                MO_ACK_BIT:   s.sda = (s.op == twm_pkg::CMD_RD_ACK) ? 1'b0 : 1'b1;
                MO_ACK_CHECK: s.ack = ~sda_in;
                default: begin
                    s.op = twm_pkg::CMD_NONE;
                    s.step = 6'd0;
                    s.wait_left = 8'd0;
                    return 1'b1;
                end
            endcase
        end
        s.op = twm_pkg::CMD_NONE;
        s.step = 6'd0;
        s.wait_left = 8'd0;
        return 1'b1;
    endfunction

    // One bus tick: a new command starts only while idle, otherwise it is ignored.
    function automatic twm_pkg::t_result bus_tick(inout t_bus_state s, input logic [2:0] c,
                                                  input logic [7:0] wr, input logic sda_in);
        twm_pkg::t_result r;
        logic             done;
        done = 1'b0;
        if (s.op == twm_pkg::CMD_NONE) begin
            if (c != twm_pkg::CMD_NONE && c != twm_pkg::CMD_RESERVED) begin
                s.op = c;
                s.step = 6'd0;
                s.wait_left = 8'd0;
                if (c == twm_pkg::CMD_WRITE) s.shreg = wr;
                done = run_steps(s, sda_in);
            end
        end else if (s.wait_left != 8'd0) begin
            s.wait_left = s.wait_left - 8'd1;
        end else begin
            done = run_steps(s, sda_in);
        end
        r.scl_level = s.scl;
        r.sda_level = s.sda;
        r.sda_drive = s.drv;
        r.busy_res = (s.op != twm_pkg::CMD_NONE);
        r.done_res = done;
        r.rd_byte = s.rd;
        r.ack_seen = s.ack;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    endtask

    function automatic logic pick_sda(input int mode);
        if (mode == SDA_HIGH) return 1'b1;
        if (mode == SDA_LOW) return 1'b0;
        return 1'($urandom_range(1));
    endfunction

    // Queues one tick and keeps the generator's copy of the engine in step with it.
    task automatic push_tick(input logic [2:0] c, input logic [7:0] wr, input logic sda);
        t_tick_item        it;
        twm_pkg::t_result  unused;
        it.cmd = c;
        it.wr_byte = wr;
        it.sda_in = sda;
        pending_q.push_back(it);
        unused = bus_tick(gen_bus, c, wr, sda);
        queued_total++;
    endtask

    // Issues a command and fills ticks until it completes; noise_pct of the filler
    // ticks carry commands that the busy engine must ignore.
    task automatic run_command(input logic [2:0] c, input logic [7:0] wr,
                               input int sda_mode, input int noise_pct);
        logic [2:0] filler;
        push_tick(c, wr, pick_sda(sda_mode));
        while (gen_bus.op != twm_pkg::CMD_NONE) begin
            filler = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7))
                                                      : twm_pkg::CMD_NONE;
            push_tick(filler, 8'($urandom), pick_sda(sda_mode));
        end
    endtask

    task automatic random_transfer();
        int         n;
        logic [2:0] c;
        n = $urandom_range(2);
        repeat (n) push_tick($urandom_range(1) ? twm_pkg::CMD_RESERVED : twm_pkg::CMD_NONE,
                             8'($urandom), pick_sda(SDA_RANDOM));
        if ($urandom_range(7) == 0) begin
            // A lone command outside a well-formed transfer.
            run_command(3'($urandom_range(7)), 8'($urandom), SDA_RANDOM, 8);
        end else begin
            run_command(twm_pkg::CMD_START, 8'($urandom), SDA_RANDOM, 8);
            n = $urandom_range(1, 3);
            repeat (n) begin
                c = 3'($urandom_range(twm_pkg::CMD_WRITE, twm_pkg::CMD_CHK_ACK));
                run_command(c, 8'($urandom), SDA_RANDOM, 8);
            end
            run_command(twm_pkg::CMD_STOP, 8'($urandom), SDA_RANDOM, 8);
        end
    endtask

    task automatic wait_drained();
        while (checked_total != queued_total) @(posedge i_clk);
    endtask

    // The engine is idle between phases, so the register write cannot land mid-command.
    task automatic set_phase(input logic [7:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        chk_bus.phase = v;
        gen_bus.phase = v;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // Sender: bursts of items with random gaps; the model advances on each accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted = bus_tick(chk_bus, i_cmd, i_wr_byte, i_sda_in);
                tick_expect_q.push_back(predicted);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    next_item = pending_q.pop_front();
                    i_cmd <= next_item.cmd;
                    i_wr_byte <= next_item.wr_byte;
                    i_sda_in <= next_item.sda_in;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches among free-running, random and periodic modes; a request adds a long hold.
    always @(posedge i_clk) begin
        stall_cyc++;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(3);
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(9) < 3);
                2: i_out_stall <= (stall_cyc % 3 == 0);
                default: i_out_stall <= ($urandom_range(9) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tick_expect_q.size() == 0) begin
                flag_mismatch("result item with nothing expected", 1, 0);
            end else begin
                want = tick_expect_q.pop_front();
                if (o_scl_level !== want.scl_level)
                    flag_mismatch("scl_level", o_scl_level, want.scl_level);
                if (o_sda_level !== want.sda_level)
                    flag_mismatch("sda_level", o_sda_level, want.sda_level);
                if (o_sda_drive !== want.sda_drive)
                    flag_mismatch("sda_drive", o_sda_drive, want.sda_drive);
                if (o_busy_res !== want.busy_res)
                    flag_mismatch("busy_res", o_busy_res, want.busy_res);
                if (o_done_res !== want.done_res)
                    flag_mismatch("done_res", o_done_res, want.done_res);
                if (o_rd_byte !== want.rd_byte)
                    flag_mismatch("rd_byte", o_rd_byte, want.rd_byte);
                if (o_ack_seen !== want.ack_seen)
                    flag_mismatch("ack_seen", o_ack_seen, want.ack_seen);
            end
            checked_total++;
        end
    end

    initial begin
        int target;
        logic [7:0] phases[4];
        chk_bus = bus_reset_state();
        gen_bus = bus_reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing first, then the corner bytes and line levels at the fastest timing.
        run_command(twm_pkg::CMD_START, 8'h00, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_CHK_ACK, 8'h00, SDA_LOW, 0);
        run_command(twm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 0);

        set_phase(8'd1);
        run_command(twm_pkg::CMD_START, 8'h00, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_WRITE, 8'hFF, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_WRITE, 8'h00, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_RD_ACK, 8'h00, SDA_HIGH, 0);
        run_command(twm_pkg::CMD_RD_NACK, 8'h00, SDA_LOW, 0);
        run_command(twm_pkg::CMD_RD_ACK, 8'h00, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_CHK_ACK, 8'h00, SDA_HIGH, 0);
        run_command(twm_pkg::CMD_CHK_ACK, 8'h00, SDA_LOW, 0);
        run_command(twm_pkg::CMD_RESERVED, 8'hFF, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_NONE, 8'hFF, SDA_RANDOM, 0);
        // Every filler tick carries a random command code while the write is in progress.
        run_command(twm_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, 100);
        run_command(twm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 0);

        // A zero phase count behaves like a phase count of one.
        set_phase(8'd0);
        run_command(twm_pkg::CMD_START, 8'h00, SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, 0);
        run_command(twm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 0);

        set_phase(8'd255);
        run_command(twm_pkg::CMD_CHK_ACK, 8'h00, SDA_LOW, 0);

        phases[0] = 8'd2;
        phases[1] = 8'd1;
        phases[2] = 8'd1;
        phases[3] = 8'($urandom_range(1, 2));
        foreach (phases[p]) begin
            set_phase(phases[p]);
            if (p == 0) hold_req++;
            target = queued_total + 20;
            while (queued_total < target) random_transfer();
            // The sender waits for every result once before going on.
            if (p == 1) begin
                wait_drained();
                random_transfer();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tick_expect_q.size() != 0)
            flag_mismatch("expected results left over", tick_expect_q.size(), 0);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/twm_pkg.sv
sv/twm_engine.sv
sv/two_wire_master_byte_engine.sv
sim/tb_top.sv
